>>> rtl/rvdec_pkg.sv
// ----------------------------------------------------------------------------
// rvdec_pkg
// Shared types and constants for the RV64IM instruction decoder: major
// opcodes, format classes, operation numbers and the decoded result record.
// ----------------------------------------------------------------------------
package rvdec_pkg;

   // Major opcodes, bits 6:0 of the instruction word
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_OPIMMW = 7'h1b;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_OPW    = 7'h3b;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_JAL    = 7'h6f;

   // Width of the packed result on the output bus
   localparam int unsigned RSP_BITS       = 67;
   localparam int unsigned RSP_TDATA_BITS = 72;

   // Format class taken from bits 6:2
   typedef enum logic [2:0] {
      FMT_U = 3'd0,
      FMT_J = 3'd1,
      FMT_I = 3'd2,
      FMT_B = 3'd3,
      FMT_S = 3'd4,
      FMT_R = 3'd5,
      FMT_X = 3'd6
   } fmt_type;

   // Operation numbers in listing order
   typedef enum logic [5:0] {
      OP_LB, OP_LH, OP_LW, OP_LD, OP_LBU, OP_LHU, OP_LWU,
      OP_ADDI, OP_SLLI, OP_SLTI, OP_SLTIU, OP_XORI, OP_SRLI, OP_SRAI, OP_ORI, OP_ANDI,
      OP_AUIPC,
      OP_ADDIW, OP_SLLIW, OP_SRLIW, OP_SRAIW,
      OP_SB, OP_SH, OP_SW, OP_SD,
      OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA, OP_OR, OP_AND,
      OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU, OP_DIV, OP_DIVU, OP_REM, OP_REMU,
      OP_LUI,
      OP_ADDW, OP_SUBW, OP_SLLW, OP_SRLW, OP_SRAW,
      OP_MULW, OP_DIVW, OP_DIVUW, OP_REMW, OP_REMUW,
      OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
      OP_JALR, OP_JAL
   } op_type;

   // Decoded result of one instruction word
   typedef struct packed {
      logic signed [31:0] immediate;
      logic [6:0]         func7_field;
      logic [2:0]         func3_field;
      logic [4:0]         src_reg_b;
      logic [4:0]         src_reg_a;
      logic [4:0]         dest_reg;
      logic [2:0]         fmt_class;
      logic [5:0]         op_index;
      logic               illegal;
   } result_type;

endpackage

>>> rtl/rvdec_decode.sv
// ----------------------------------------------------------------------------
// rvdec_decode
// Combinational decode of one instruction word into operation number,
// format class, register and function fields and the format's immediate.
// ----------------------------------------------------------------------------
module rvdec_decode (
   input  logic [31:0]            instr_word,
   output rvdec_pkg::result_type  result
);

   logic [6:0]          opcode;
   logic [4:0]          fmt_bits;
   logic [2:0]          f3;
   logic [6:0]          f7;
   logic                alt;
   logic                bad;
   rvdec_pkg::op_type   op;
   rvdec_pkg::fmt_type  fmt;
   logic [31:0]         imm;

   assign opcode   = instr_word[6:0];
   assign fmt_bits = instr_word[6:2];
   assign f3       = instr_word[14:12];
   assign f7       = instr_word[31:25];
   assign alt      = (f7 != 7'd0);

   // Classify the format from bits 6:2 only
   always_comb begin
      if ((fmt_bits & 5'h17) == 5'h05) begin
         fmt = rvdec_pkg::FMT_U;
      end else if (fmt_bits == 5'h1b) begin
         fmt = rvdec_pkg::FMT_J;
      end else if (fmt_bits == 5'h18) begin
         fmt = rvdec_pkg::FMT_B;
      end else if (fmt_bits == 5'h08) begin
         fmt = rvdec_pkg::FMT_S;
      end else if ((fmt_bits & 5'h1d) == 5'h0c) begin
         fmt = rvdec_pkg::FMT_R;
      end else if ((fmt_bits & 5'h1b) == 5'h00 || fmt_bits == 5'h06 ||
                   fmt_bits == 5'h19 || fmt_bits == 5'h1c) begin
         fmt = rvdec_pkg::FMT_I;
      end else begin
         fmt = rvdec_pkg::FMT_X;
      end
   end

   // Select and sign-extend the immediate of the format
   always_comb begin
      unique case (fmt)
         rvdec_pkg::FMT_U: imm = {instr_word[31:12], 12'd0};
         rvdec_pkg::FMT_J: imm = {{12{instr_word[31]}}, instr_word[19:12], instr_word[20],
                                  instr_word[30:21], 1'b0};
         rvdec_pkg::FMT_I: imm = {{20{instr_word[31]}}, instr_word[31:20]};
         rvdec_pkg::FMT_B: imm = {{20{instr_word[31]}}, instr_word[7], instr_word[30:25],
                                  instr_word[11:8], 1'b0};
         rvdec_pkg::FMT_S: imm = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
         default:          imm = 32'd0;
      endcase
   end

   // Name the operation; unmatched words flag illegal with operation zero
   always_comb begin
      op  = rvdec_pkg::OP_LB;
      bad = 1'b0;
      unique case (opcode)
         rvdec_pkg::OPC_LOAD: begin
            case (f3)
               3'd0:    op = rvdec_pkg::OP_LB;
               3'd1:    op = rvdec_pkg::OP_LH;
               3'd2:    op = rvdec_pkg::OP_LW;
               3'd3:    op = rvdec_pkg::OP_LD;
               3'd4:    op = rvdec_pkg::OP_LBU;
               3'd5:    op = rvdec_pkg::OP_LHU;
               3'd6:    op = rvdec_pkg::OP_LWU;
               default: bad = 1'b1;
            endcase
         end
         rvdec_pkg::OPC_OPIMM: begin
            case (f3)
               3'd0:    op = rvdec_pkg::OP_ADDI;
               3'd1:    op = rvdec_pkg::OP_SLLI;
               3'd2:    op = rvdec_pkg::OP_SLTI;
               3'd3:    op = rvdec_pkg::OP_SLTIU;
               3'd4:    op = rvdec_pkg::OP_XORI;
               3'd5:    op = instr_word[30] ? rvdec_pkg::OP_SRAI : rvdec_pkg::OP_SRLI;
               3'd6:    op = rvdec_pkg::OP_ORI;
               default: op = rvdec_pkg::OP_ANDI;
            endcase
         end
         rvdec_pkg::OPC_AUIPC: op = rvdec_pkg::OP_AUIPC;
         rvdec_pkg::OPC_OPIMMW: begin
            case (f3)
               3'd0:    op = rvdec_pkg::OP_ADDIW;
               3'd1:    op = rvdec_pkg::OP_SLLIW;
               3'd5:    op = alt ? rvdec_pkg::OP_SRAIW : rvdec_pkg::OP_SRLIW;
               default: bad = 1'b1;
            endcase
         end
         rvdec_pkg::OPC_STORE: begin
            case (f3)
               3'd0:    op = rvdec_pkg::OP_SB;
               3'd1:    op = rvdec_pkg::OP_SH;
               3'd2:    op = rvdec_pkg::OP_SW;
               3'd3:    op = rvdec_pkg::OP_SD;
               default: bad = 1'b1;
            endcase
         end
         rvdec_pkg::OPC_OP: begin
            if (f7[0]) begin
               case (f3)
                  3'd0:    op = rvdec_pkg::OP_MUL;
                  3'd1:    op = rvdec_pkg::OP_MULH;
                  3'd2:    op = rvdec_pkg::OP_MULHSU;
                  3'd3:    op = rvdec_pkg::OP_MULHU;
                  3'd4:    op = rvdec_pkg::OP_DIV;
                  3'd5:    op = rvdec_pkg::OP_DIVU;
                  3'd6:    op = rvdec_pkg::OP_REM;
                  default: op = rvdec_pkg::OP_REMU;
               endcase
            end else begin
               case (f3)
                  3'd0:    op = alt ? rvdec_pkg::OP_SUB : rvdec_pkg::OP_ADD;
                  3'd1:    op = rvdec_pkg::OP_SLL;
                  3'd2:    op = rvdec_pkg::OP_SLT;
                  3'd3:    op = rvdec_pkg::OP_SLTU;
                  3'd4:    op = rvdec_pkg::OP_XOR;
                  3'd5:    op = alt ? rvdec_pkg::OP_SRA : rvdec_pkg::OP_SRL;
                  3'd6:    op = rvdec_pkg::OP_OR;
                  default: op = rvdec_pkg::OP_AND;
               endcase
            end
         end
         rvdec_pkg::OPC_LUI: op = rvdec_pkg::OP_LUI;
         rvdec_pkg::OPC_OPW: begin
            if (f7[0]) begin
               case (f3)
                  3'd0:    op = rvdec_pkg::OP_MULW;
                  3'd4:    op = rvdec_pkg::OP_DIVW;
                  3'd5:    op = rvdec_pkg::OP_DIVUW;
                  3'd6:    op = rvdec_pkg::OP_REMW;
                  3'd7:    op = rvdec_pkg::OP_REMUW;
                  default: bad = 1'b1;
               endcase
            end else begin
               case (f3)
                  3'd0:    op = alt ? rvdec_pkg::OP_SUBW : rvdec_pkg::OP_ADDW;
                  3'd1:    op = rvdec_pkg::OP_SLLW;
                  3'd5:    op = alt ? rvdec_pkg::OP_SRAW : rvdec_pkg::OP_SRLW;
                  default: bad = 1'b1;
               endcase
            end
         end
         rvdec_pkg::OPC_BRANCH: begin
            case (f3)
               3'd0:    op = rvdec_pkg::OP_BEQ;
               3'd1:    op = rvdec_pkg::OP_BNE;
               3'd4:    op = rvdec_pkg::OP_BLT;
               3'd5:    op = rvdec_pkg::OP_BGE;
               3'd6:    op = rvdec_pkg::OP_BLTU;
               3'd7:    op = rvdec_pkg::OP_BGEU;
               default: bad = 1'b1;
            endcase
         end
         rvdec_pkg::OPC_JALR: op = rvdec_pkg::OP_JALR;
         rvdec_pkg::OPC_JAL:  op = rvdec_pkg::OP_JAL;
         default:             bad = 1'b1;
      endcase
   end

   // Assemble the result record
   always_comb begin
      result.illegal     = bad;
      result.op_index    = bad ? 6'd0 : 6'(op);
      result.fmt_class   = 3'(fmt);
      result.dest_reg    = instr_word[11:7];
      result.src_reg_a   = instr_word[19:15];
      result.src_reg_b   = instr_word[24:20];
      result.func3_field = f3;
      result.func7_field = f7;
      result.immediate   = imm;
   end

endmodule

>>> rtl/rv64im_instruction_decoder_unit.sv
// ----------------------------------------------------------------------------
// rv64im_instruction_decoder_unit
// Streaming RV64IM instruction decoder, one instruction word per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one 32-bit instruction word per transfer. The
//   rsp_ channel returns one decoded record per word, in order: illegal flag,
//   operation number, format class, rd, rs1, rs2, funct3, funct7 and the
//   sign-extended immediate.
//   From the req_ transfer to rsp_tvalid, the word is captured in an input
//   register, decoded by one pass of field-matching logic and captured in
//   the output register. Throughput is one word per cycle while the receiver
//   does not stall; the decode pass sets that figure.
//   When the receiver stalls, the output register holds its record and the
//   input register holds its word; req_tready drops only once both stages
//   are full, and the stages resume without loss when rsp_tready returns.
//   Synchronous reset empties both stages; no other state is kept.
// ----------------------------------------------------------------------------
module rv64im_instruction_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   // Instruction input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] instr_word
   // Decoded result
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [rvdec_pkg::RSP_TDATA_BITS-1:0] rsp_tdata
   // rsp_tdata fields from bit 0: illegal[0], op_index[6:1], fmt_class[9:7],
   // dest_reg[14:10], src_reg_a[19:15], src_reg_b[24:20], func3_field[27:25],
   // func7_field[34:28], immediate[66:35], zero fill[71:67]
);

   logic                  word_valid_ff;
   logic                  word_valid_in;
   logic [31:0]           word_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rvdec_pkg::result_type rsp_data_ff;
   rvdec_pkg::result_type decoded;
   logic                  out_load;
   logic                  word_load;

   // Advance the output stage when it is empty or being drained
   assign out_load  = !rsp_valid_ff || rsp_tready;
   assign req_tready = !word_valid_ff || out_load;
   assign word_load = req_tvalid && req_tready;

   always_comb begin
      word_valid_in = word_valid_ff;
      if (req_tready) begin
         word_valid_in = req_tvalid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = word_valid_ff;
      end
   end

   // Stage control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         word_valid_ff <= word_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Capture the incoming word
   always_ff @(posedge clock) begin
      if (word_load) begin
         word_ff <= req_tdata;
      end
   end

   rvdec_decode u_decode (
      .instr_word (word_ff),
      .result     (decoded)
   );

   // Capture the decoded record
   always_ff @(posedge clock) begin
      if (out_load && word_valid_ff) begin
         rsp_data_ff <= decoded;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(rvdec_pkg::RSP_TDATA_BITS - rvdec_pkg::RSP_BITS){1'b0}},
                        rsp_data_ff};

endmodule

>>> sim/tb_rv64im_instruction_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_rv64im_instruction_decoder_unit
// Self-checking bench for the streaming RV64IM decoder. A short list of edge
// words is followed by mostly well-formed random instructions and some raw
// noise. Each accepted word is decoded again here and every record returned
// on the result stream is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_rv64im_instruction_decoder_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS = 1575;
   localparam int CALM_TAIL    = 300;
   localparam int STALL_AT     = 500;
   localparam int HOLD_CYCLES  = 150;

   // funct3 values that split an opcode group
   localparam logic [2:0] F3_ADD = 3'd0;
   localparam logic [2:0] F3_SLL = 3'd1;
   localparam logic [2:0] F3_XOR = 3'd4;
   localparam logic [2:0] F3_SHR = 3'd5;
   localparam logic [2:0] F3_OR  = 3'd6;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] instr_word
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [rvdec_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;
   // rsp_tdata fields from bit 0: illegal, op_index, fmt_class, dest_reg,
   // src_reg_a, src_reg_b, func3_field, func7_field, immediate, zero fill

   bit idle_on       = 1'b1;
   bit stall_request = 1'b0;

   // Decodes words on its own and holds the records still owed by the block
   class decode_ledger;
      rvdec_pkg::result_type expected_records[$];
      logic [31:0]           expected_words[$];
      int                    failures;
      int                    checked;
      int                    illegal_words;
      bit [63:0]             ops_seen;

      function rvdec_pkg::result_type decode_word(logic [31:0] w);
         rvdec_pkg::result_type r;
         rvdec_pkg::op_type     op;
         rvdec_pkg::fmt_type    fmt;
         logic       ok;
         logic       alt;
         logic [2:0] f3;
         logic [4:0] fb;
         f3  = w[14:12];
         fb  = w[6:2];
         alt = |w[31:25];
         ok  = 1'b1;
         op  = rvdec_pkg::OP_LB;
         // operation from opcode, funct3 and funct7
         case (w[6:0])
            rvdec_pkg::OPC_LOAD: begin
               op = rvdec_pkg::op_type'(rvdec_pkg::OP_LB + f3);
               ok = ~&f3;
            end
            rvdec_pkg::OPC_OPIMM: begin
               if (f3 == F3_SHR) op = w[30] ? rvdec_pkg::OP_SRAI : rvdec_pkg::OP_SRLI;
               else if (f3 < F3_SHR) op = rvdec_pkg::op_type'(rvdec_pkg::OP_ADDI + f3);
               else op = rvdec_pkg::op_type'(rvdec_pkg::OP_ORI + (f3 - F3_OR));
            end
            rvdec_pkg::OPC_AUIPC: op = rvdec_pkg::OP_AUIPC;
            rvdec_pkg::OPC_OPIMMW: begin
               if (f3 == F3_ADD) op = rvdec_pkg::OP_ADDIW;
               else if (f3 == F3_SLL) op = rvdec_pkg::OP_SLLIW;
               else if (f3 == F3_SHR) op = alt ? rvdec_pkg::OP_SRAIW : rvdec_pkg::OP_SRLIW;
               else ok = 1'b0;
            end
            rvdec_pkg::OPC_STORE: begin
               op = rvdec_pkg::op_type'(rvdec_pkg::OP_SB + f3);
               ok = ~f3[2];
            end
            rvdec_pkg::OPC_OP: begin
               if (w[25]) op = rvdec_pkg::op_type'(rvdec_pkg::OP_MUL + f3);
               else if (f3 == F3_ADD) op = alt ? rvdec_pkg::OP_SUB : rvdec_pkg::OP_ADD;
               else if (f3 == F3_SHR) op = alt ? rvdec_pkg::OP_SRA : rvdec_pkg::OP_SRL;
               else if (f3 < F3_SHR)
                  op = rvdec_pkg::op_type'(rvdec_pkg::OP_SLL + (f3 - F3_SLL));
               else op = rvdec_pkg::op_type'(rvdec_pkg::OP_OR + (f3 - F3_OR));
            end
            rvdec_pkg::OPC_LUI: op = rvdec_pkg::OP_LUI;
            rvdec_pkg::OPC_OPW: begin
               if (w[25]) begin
                  if (f3 == F3_ADD) op = rvdec_pkg::OP_MULW;
                  else if (f3 >= F3_XOR)
                     op = rvdec_pkg::op_type'(rvdec_pkg::OP_DIVW + (f3 - F3_XOR));
                  else ok = 1'b0;
               end else if (f3 == F3_ADD) op = alt ? rvdec_pkg::OP_SUBW : rvdec_pkg::OP_ADDW;
               else if (f3 == F3_SLL) op = rvdec_pkg::OP_SLLW;
               else if (f3 == F3_SHR) op = alt ? rvdec_pkg::OP_SRAW : rvdec_pkg::OP_SRLW;
               else ok = 1'b0;
            end
            rvdec_pkg::OPC_BRANCH: begin
               if (f3 < F3_XOR) op = rvdec_pkg::op_type'(rvdec_pkg::OP_BEQ + f3);
               else op = rvdec_pkg::op_type'(rvdec_pkg::OP_BLT + (f3 - F3_XOR));
               ok = !(f3[2:1] == 2'b01);
            end
            rvdec_pkg::OPC_JALR: op = rvdec_pkg::OP_JALR;
            rvdec_pkg::OPC_JAL: op = rvdec_pkg::OP_JAL;
            default: ok = 1'b0;
         endcase

         // format class from bits 6:2 alone, bits 1:0 ignored
         if ((fb & 5'h17) == rvdec_pkg::OPC_AUIPC[6:2]) fmt = rvdec_pkg::FMT_U;   // auipc, lui
         else if (fb == rvdec_pkg::OPC_JAL[6:2]) fmt = rvdec_pkg::FMT_J;
         else if (fb == rvdec_pkg::OPC_BRANCH[6:2]) fmt = rvdec_pkg::FMT_B;
         else if (fb == rvdec_pkg::OPC_STORE[6:2]) fmt = rvdec_pkg::FMT_S;
         else if ((fb & 5'h1D) == rvdec_pkg::OPC_OP[6:2]) fmt = rvdec_pkg::FMT_R;  // op, op-32
         else if ((fb & 5'h1B) == 5'h00 || fb == rvdec_pkg::OPC_OPIMMW[6:2] ||
                  fb == rvdec_pkg::OPC_JALR[6:2] || fb == 5'h1C)
            fmt = rvdec_pkg::FMT_I;  // 5'h1C: system
         else fmt = rvdec_pkg::FMT_X;

         // immediate of the format class
         case (fmt)
            rvdec_pkg::FMT_U: r.immediate = {w[31:12], 12'b0};
            rvdec_pkg::FMT_J: r.immediate = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
            rvdec_pkg::FMT_I: r.immediate = {{21{w[31]}}, w[30:20]};
            rvdec_pkg::FMT_B: r.immediate = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
            rvdec_pkg::FMT_S: r.immediate = {{21{w[31]}}, w[30:25], w[11:7]};
            default: r.immediate = '0;
         endcase

         r.illegal     = ~ok;
         r.op_index    = ok ? op : '0;
         r.fmt_class   = fmt;
         r.dest_reg    = w[11:7];
         r.src_reg_a   = w[19:15];
         r.src_reg_b   = w[24:20];
         r.func3_field = w[14:12];
         r.func7_field = w[31:25];
         return r;
      endfunction

      // Note an accepted word and queue its record
      function void note_word(logic [31:0] w);
         rvdec_pkg::result_type r;
         r = decode_word(w);
         expected_records.push_back(r);
         expected_words.push_back(w);
         if (r.illegal) illegal_words++;
         else ops_seen[r.op_index] = 1'b1;
      endfunction

      function void field_check(string name, logic [31:0] word,
                                logic [31:0] want_v, logic [31:0] got_v);
         if (want_v !== got_v) begin
            failures++;
            if (failures <= 10)
               $display("ERROR: word %h %s expected %h got %h", word, name, want_v, got_v);
         end
      endfunction

      // Compare one returned record with the oldest one owed
      function void check_record(rvdec_pkg::result_type got);
         rvdec_pkg::result_type want;
         logic [31:0]           word;
         if (expected_records.size() == 0) begin
            failures++;
            if (failures <= 10) $display("ERROR: record %h arrived with none owed", got);
            return;
         end
         want = expected_records.pop_front();
         word = expected_words.pop_front();
         checked++;
         field_check("illegal", word, want.illegal, got.illegal);
         field_check("op_index", word, want.op_index, got.op_index);
         field_check("fmt_class", word, want.fmt_class, got.fmt_class);
         field_check("dest_reg", word, want.dest_reg, got.dest_reg);
         field_check("src_reg_a", word, want.src_reg_a, got.src_reg_a);
         field_check("src_reg_b", word, want.src_reg_b, got.src_reg_b);
         field_check("func3_field", word, want.func3_field, got.func3_field);
         field_check("func7_field", word, want.func7_field, got.func7_field);
         field_check("immediate", word, want.immediate, got.immediate);
      endfunction
   endclass

   decode_ledger ledger = new();

   rv64im_instruction_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // Offer one word, idle first at random, hold until the transfer
   task automatic send_word(input logic [31:0] w);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      ledger.note_word(w);
   endtask

   function automatic logic [6:0] pick_opcode(int k);
      case (k)
         0: return rvdec_pkg::OPC_LOAD;
         1: return rvdec_pkg::OPC_OPIMM;
         2: return rvdec_pkg::OPC_AUIPC;
         3: return rvdec_pkg::OPC_OPIMMW;
         4: return rvdec_pkg::OPC_STORE;
         5: return rvdec_pkg::OPC_OP;
         6: return rvdec_pkg::OPC_LUI;
         7: return rvdec_pkg::OPC_OPW;
         8: return rvdec_pkg::OPC_BRANCH;
         9: return rvdec_pkg::OPC_JALR;
         default: return rvdec_pkg::OPC_JAL;
      endcase
   endfunction

   // Mostly valid opcodes with funct7 biased toward the meaningful values
   function automatic logic [31:0] random_word();
      logic [31:0] w;
      w = $urandom;
      if ($urandom_range(0, 9) >= 2) begin
         w[6:0] = pick_opcode($urandom_range(0, 10));
         case ($urandom_range(0, 3))
            0: w[31:25] = 7'h00;
            1: w[31:25] = 7'h20;
            2: w[31:25] = 7'h01;
            default: ;
         endcase
      end
      return w;
   endfunction

   // Result side: random stalls, one long hold-off on request
   initial begin
      forever begin
         if (stall_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            stall_request = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Check every returned record
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         ledger.check_record(rvdec_pkg::result_type'(rsp_tdata[rvdec_pkg::RSP_BITS-1:0]));
   end

   // Stimulus and end of run
   initial begin
      int n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // edge words: all zeros and ones, immediate extremes, special encodings
      send_word(32'h0000_0000);
      send_word(32'hFFFF_FFFF);
      send_word(32'h7FF0_0013);
      send_word(32'h8000_0013);
      send_word(32'hFFFF_F037);
      send_word(32'h7FFF_F017);
      send_word(32'h7FFF_F06F);
      send_word(32'h8000_006F);
      send_word(32'h7E00_0FE3);
      send_word(32'h8000_7063);
      send_word(32'h7E00_0FA3);
      send_word(32'h8000_3023);
      send_word(32'h4000_5013);   // srai by bit 30
      send_word(32'h0200_5013);   // srli with funct7 not zero
      send_word(32'h0200_501B);   // sraiw on any nonzero funct7
      send_word(32'h0400_0033);   // sub on any nonzero funct7
      send_word(32'h0200_7033);   // remu through bit 25
      send_word(32'h0000_603B);   // op-32 hole
      send_word(32'h0200_103B);   // M-extension op-32 hole
      send_word(32'h0000_7003);   // load hole
      send_word(32'h0000_2063);   // branch hole
      send_word(32'hFFF0_1067);   // jalr with funct3 set
      send_word(32'h0000_0010);   // low bits clear, format still decoded
      send_word(32'h0000_001F);   // unknown format

      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n == STALL_AT) stall_request = 1'b1;
         if (n == RANDOM_WORDS - CALM_TAIL) idle_on = 1'b0;
         send_word(random_word());
      end
      req_tvalid <= 1'b0;

      // drain, then watch for stray records
      while (ledger.expected_records.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Run covered %0d decoded words, %0d illegal, %0d of 62 operations,",
               ledger.checked, ledger.illegal_words, $countones(ledger.ops_seen));
      $display("with random stalls on both sides and one long hold on results.");
      if (ledger.failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d field mismatches", ledger.failures);
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Timeout guard
   initial begin
      #2_000_000;
      $display("Timeout with %0d records owed", ledger.expected_records.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
